### rtl/banked_register_file_mode_switch_top_defines.svh
// assertion macros shared by the banked register file rtl
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_TOP_DEFINES_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define BFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("banked register file check failed");

// consequent must hold in the cycle after the antecedent
`define BFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("banked register file check failed");

`else

`define BFR_ASSERT(lbl, prop)
`define BFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/bfr_pkg.sv
// types, codes and constants of the banked register file
`default_nettype none

package bfr_pkg;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 5;
    localparam int NUM_REGS   = 16;
    localparam int BANK_COUNT = 6;
    localparam int HIGH_COUNT = 5;
    localparam int SPSR_COUNT = 5;
    localparam int HIGH_BASE  = 8;

    // request kinds
    localparam logic [2:0] KIND_READ_REG   = 3'd0;
    localparam logic [2:0] KIND_WRITE_REG  = 3'd1;
    localparam logic [2:0] KIND_WRITE_CPSR = 3'd2;
    localparam logic [2:0] KIND_READ_SPSR  = 3'd3;
    localparam logic [2:0] KIND_WRITE_SPSR = 3'd4;
    localparam logic [2:0] KIND_IRQ        = 3'd5;
    localparam logic [2:0] KIND_BOOT       = 3'd6;
    localparam logic [2:0] KIND_READ_CPSR  = 3'd7;

    // processor modes
    localparam logic [MODE_W-1:0] MODE_USR = 5'b10000;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'b10001;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'b10010;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'b10011;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'b10111;
    localparam logic [MODE_W-1:0] MODE_UND = 5'b11011;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'b11111;

    // r13/r14 bank slots
    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    // spsr slot of the irq mode
    localparam logic [2:0] IRQ_SAVE_SLOT = 3'd1;

    localparam logic [DATA_W-1:0] CPSR_RESET     = 32'h0000_001F;
    localparam logic [DATA_W-1:0] IRQ_CLEAR_MASK = 32'h0000_003F;
    localparam logic [DATA_W-1:0] IRQ_ENTRY_BITS = 32'h0000_0092;
    localparam logic [DATA_W-1:0] IRQ_VECTOR     = 32'h0000_0018;
    localparam logic [DATA_W-1:0] BOOT_SP_SYS    = 32'h0380_FD80;
    localparam logic [DATA_W-1:0] BOOT_SP_IRQ    = 32'h0380_FF80;
    localparam logic [DATA_W-1:0] BOOT_SP_SVC    = 32'h0380_FFC0;
    localparam logic [DATA_W-1:0] ARM_LR_OFFSET  = 32'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        reg_index;
        logic [DATA_W-1:0] value;
        logic              irq_pending;
        logic              irq_enabled;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_taken;
        logic              pc_written;
    } res_t;

    // r13/r14 bank of a mode, invalid modes share the user bank
    function automatic logic [2:0] bank_of(input logic [MODE_W-1:0] mode);
        logic [2:0] b;
        unique case (mode)
            MODE_FIQ: b = BANK_FIQ;
            MODE_IRQ: b = BANK_IRQ;
            MODE_SVC: b = BANK_SVC;
            MODE_ABT: b = BANK_ABT;
            MODE_UND: b = BANK_UND;
            default:  b = BANK_USR;
        endcase
        return b;
    endfunction

    // spsr slot of a mode, msb set when the mode has one
    function automatic logic [3:0] spsr_of(input logic [MODE_W-1:0] mode);
        logic [3:0] s;
        unique case (mode)
            MODE_FIQ: s = 4'b1000;
            MODE_IRQ: s = 4'b1001;
            MODE_SVC: s = 4'b1010;
            MODE_ABT: s = 4'b1011;
            MODE_UND: s = 4'b1100;
            default:  s = 4'b0000;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/bfr_core.sv
// register state and single pass execution of one request
`default_nettype none
`include "banked_register_file_mode_switch_top_defines.svh"

module bfr_core
    import bfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  exec,
    input  wire item_t item,
    output res_t       res
);

    logic [DATA_W-1:0] vis_reg   [NUM_REGS];
    logic [DATA_W-1:0] vis_next  [NUM_REGS];
    logic [DATA_W-1:0] cpsr_reg;
    logic [DATA_W-1:0] cpsr_next;
    logic [MODE_W-1:0] last_mode_reg;
    logic [MODE_W-1:0] last_mode_next;
    logic [DATA_W-1:0] bank_reg  [BANK_COUNT][2];
    logic [DATA_W-1:0] bank_next [BANK_COUNT][2];
    logic [DATA_W-1:0] fiq_high_reg  [HIGH_COUNT];
    logic [DATA_W-1:0] fiq_high_next [HIGH_COUNT];
    logic [DATA_W-1:0] usr_high_reg  [HIGH_COUNT];
    logic [DATA_W-1:0] usr_high_next [HIGH_COUNT];
    logic [DATA_W-1:0] spsr_reg  [SPSR_COUNT];
    logic [DATA_W-1:0] spsr_next [SPSR_COUNT];

    logic              irq_ok;
    logic [3:0]        cur_spsr;

    assign irq_ok   = !cpsr_reg[7] && item.irq_pending && item.irq_enabled;
    assign cur_spsr = spsr_of(cpsr_reg[MODE_W-1:0]);

    always_comb
    begin
        logic              do_swap;
        logic              irq_entry;
        logic [MODE_W-1:0] old_mode;
        logic [MODE_W-1:0] new_mode;
        logic [2:0]        ob;
        logic [2:0]        nb;

        vis_next       = vis_reg;
        cpsr_next      = cpsr_reg;
        last_mode_next = last_mode_reg;
        bank_next      = bank_reg;
        fiq_high_next  = fiq_high_reg;
        usr_high_next  = usr_high_reg;
        spsr_next      = spsr_reg;
        res            = '0;
        do_swap        = 1'b0;
        irq_entry      = 1'b0;
        old_mode       = last_mode_reg;
        new_mode       = last_mode_reg;

        unique case (item.kind)
            KIND_READ_REG:
            begin
                res.read_data = vis_reg[item.reg_index];
            end
            KIND_WRITE_REG:
            begin
                vis_next[item.reg_index] = item.value;
                res.pc_written = (item.reg_index == 4'hF);
            end
            KIND_WRITE_CPSR:
            begin
                cpsr_next = item.value;
                new_mode  = item.value[MODE_W-1:0];
                do_swap   = 1'b1;
            end
            KIND_READ_SPSR:
            begin
                res.read_data = cur_spsr[3] ? spsr_reg[cur_spsr[2:0]] : cpsr_reg;
            end
            KIND_WRITE_SPSR:
            begin
                if (cur_spsr[3])
                begin
                    spsr_next[cur_spsr[2:0]] = item.value;
                end
            end
            KIND_IRQ:
            begin
                if (irq_ok)
                begin
                    cpsr_next      = (cpsr_reg & ~IRQ_CLEAR_MASK) | IRQ_ENTRY_BITS;
                    new_mode       = MODE_IRQ;
                    do_swap        = 1'b1;
                    irq_entry      = 1'b1;
                    res.irq_taken  = 1'b1;
                    res.pc_written = 1'b1;
                end
            end
            KIND_BOOT:
            begin
                cpsr_next      = CPSR_RESET;
                last_mode_next = MODE_SYS;
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    vis_next[i] = '0;
                end
                vis_next[12]          = item.value;
                vis_next[13]          = BOOT_SP_SYS;
                vis_next[14]          = item.value;
                vis_next[15]          = item.value;
                bank_next[BANK_IRQ][0] = BOOT_SP_IRQ;
                bank_next[BANK_IRQ][1] = '0;
                bank_next[BANK_SVC][0] = BOOT_SP_SVC;
                bank_next[BANK_SVC][1] = '0;
                res.pc_written        = 1'b1;
            end
            KIND_READ_CPSR:
            begin
                res.read_data = cpsr_reg;
            end
        endcase

        // bank swap from the mode the visible registers belong to
        ob = bank_of(old_mode);
        nb = bank_of(new_mode);
        if (do_swap)
        begin
            last_mode_next = new_mode;
            if (!(old_mode == new_mode ||
                  (old_mode == MODE_USR && new_mode == MODE_SYS) ||
                  (old_mode == MODE_SYS && new_mode == MODE_USR)))
            begin
                if (old_mode == MODE_FIQ)
                begin
                    for (int i = 0; i < HIGH_COUNT; i++)
                    begin
                        fiq_high_next[i]       = vis_next[HIGH_BASE + i];
                        vis_next[HIGH_BASE + i] = usr_high_reg[i];
                    end
                end
                bank_next[ob][0] = vis_next[13];
                bank_next[ob][1] = vis_next[14];
                if (new_mode == MODE_FIQ)
                begin
                    for (int i = 0; i < HIGH_COUNT; i++)
                    begin
                        usr_high_next[i]        = vis_next[HIGH_BASE + i];
                        vis_next[HIGH_BASE + i] = fiq_high_next[i];
                    end
                end
                vis_next[13] = bank_next[nb][0];
                vis_next[14] = bank_next[nb][1];
            end
        end

        // irq entry tail: save status, link and vector
        if (irq_entry)
        begin
            spsr_next[IRQ_SAVE_SLOT] = cpsr_reg;
            vis_next[14] = vis_reg[15] - (cpsr_reg[5] ? '0 : ARM_LR_OFFSET);
            vis_next[15] = IRQ_VECTOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                vis_reg[i] <= '0;
            end
            for (int i = 0; i < BANK_COUNT; i++)
            begin
                bank_reg[i][0] <= '0;
                bank_reg[i][1] <= '0;
            end
            for (int i = 0; i < HIGH_COUNT; i++)
            begin
                fiq_high_reg[i] <= '0;
                usr_high_reg[i] <= '0;
            end
            for (int i = 0; i < SPSR_COUNT; i++)
            begin
                spsr_reg[i] <= '0;
            end
            cpsr_reg      <= CPSR_RESET;
            last_mode_reg <= MODE_SYS;
        end
        else if (exec)
        begin
            vis_reg       <= vis_next;
            bank_reg      <= bank_next;
            fiq_high_reg  <= fiq_high_next;
            usr_high_reg  <= usr_high_next;
            spsr_reg      <= spsr_next;
            cpsr_reg      <= cpsr_next;
            last_mode_reg <= last_mode_next;
        end
    end

    `BFR_ASSERT_NEXT(a_boot_state, exec && item.kind == KIND_BOOT,
        vis_reg[13] == BOOT_SP_SYS && last_mode_reg == MODE_SYS && cpsr_reg == CPSR_RESET)
    `BFR_ASSERT_NEXT(a_irq_entry, exec && item.kind == KIND_IRQ && irq_ok,
        last_mode_reg == MODE_IRQ && cpsr_reg[7] && vis_reg[15] == IRQ_VECTOR)
    `BFR_ASSERT_NEXT(a_cpsr_tracks, exec && item.kind == KIND_WRITE_CPSR,
        last_mode_reg == cpsr_reg[MODE_W-1:0])

endmodule

`default_nettype wire

### rtl/banked_register_file_mode_switch_top.sv
// top level of the banked register file with mode switching
`default_nettype none
`include "banked_register_file_mode_switch_top_defines.svh"

// banked register file of an arm7 style core. one request is taken on every
// clock where start is high; busy is held low, so requests may follow each
// other back to back. a request is captured in an input register, executed in
// the next cycle by the core (register read or write, cpsr/spsr access, irq
// entry or boot, with the bank swap done as parallel register moves), and its
// result is shown on read_data, irq_taken and pc_written while done is high
// for exactly one cycle, once it has passed the input and result registers. the receiver
// cannot stall: every result must be taken in the cycle that it is shown.
// the sustained rate is one request per cycle, set by the single execute
// stage that reads and writes all register state in one pass.
module banked_register_file_mode_switch_top
    import bfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        kind,
    input  wire logic [3:0]        reg_index,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              irq_pending,
    input  wire logic              irq_enabled,
    output logic                   done,
    output logic [DATA_W-1:0]      read_data,
    output logic                   irq_taken,
    output logic                   pc_written
);

    // input stage
    logic  valid_reg;
    item_t item_reg;

    // result stage
    logic  done_reg;
    res_t  res_reg;
    res_t  core_res;

    logic  accept;

    // execute stage never blocks, so requests are always taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind        <= kind;
            item_reg.reg_index   <= reg_index;
            item_reg.value       <= value;
            item_reg.irq_pending <= irq_pending;
            item_reg.irq_enabled <= irq_enabled;
        end
        if (valid_reg)
        begin
            res_reg <= core_res;
        end
    end

    // register state and the single pass execution
    bfr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (valid_reg),
        .item  (item_reg),
        .res   (core_res)
    );

    assign done       = done_reg;
    assign read_data  = res_reg.read_data;
    assign irq_taken  = res_reg.irq_taken;
    assign pc_written = res_reg.pc_written;

    // every accepted request passes valid_reg and then reaches the result strobe
    `BFR_ASSERT_NEXT(a_accept_exec, accept, valid_reg)
    `BFR_ASSERT_NEXT(a_exec_done, valid_reg, done_reg)
    // an irq entry always redirects the pc
    `BFR_ASSERT(a_irq_flush, !done_reg || !res_reg.irq_taken || res_reg.pc_written)

endmodule

`default_nettype wire
